// ===== sv/tsp_pkg.sv =====
// Package with the parse phase, kind and error codes shared by the token stream parser.
package tsp_pkg;

    typedef enum logic [3:0] {
        PH_TOP    = 4'd0,
        PH_NAME   = 4'd1,
        PH_OPEN1  = 4'd2,
        PH_OPEN2  = 4'd3,
        PH_FIELD  = 4'd4,
        PH_KEY    = 4'd5,
        PH_DELIM1 = 4'd6,
        PH_DELIM2 = 4'd7,
        PH_VSTART = 4'd8,
        PH_VALUE  = 4'd9,
        PH_ESC    = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        KIND_SKIP  = 3'd0,
        KIND_NAME  = 3'd1,
        KIND_KEY   = 3'd2,
        KIND_VALUE = 3'd3,
        KIND_VEND  = 3'd4,
        KIND_CLOSE = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_WS_AT_KEY   = 4'd1,
        ERR_BAD_KEY     = 4'd2,
        ERR_OPEN_DELIM  = 4'd3,
        ERR_FIELD_DELIM = 4'd4,
        ERR_NO_VALUE    = 4'd5,
        ERR_OPEN_VALUE  = 4'd6,
        ERR_OPEN_ESCAPE = 4'd7,
        ERR_OPEN_TOKEN  = 4'd8
    } t_error;

    typedef struct packed {
        t_phase phase;
        t_error error;
    } t_parse_state;

    typedef struct packed {
        t_parse_state next_state;
        t_kind        kind;
        t_error       error_code;
        logic         stream_ok;
    } t_step_result;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_ctrl_ws(input logic [7:0] c);
        return c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0B || c == 8'h0C;
    endfunction

endpackage

// ===== sv/token_stream_parser.sv =====
// Top level of the token stream parser: input register, parse step, state and result register.
// The parser checks a byte stream against the grammar name { key: "value" ... } and labels
// every byte with one result transaction. A byte is taken into an input register, judged by
// the combinational step logic against the parse phase and sticky error, and the label is
// loaded into an output register; one byte per clock is sustained while m_axis_tready is held
// high, and the state register loop through the step logic sets that rate. The result for
// the byte marked last carries tlast, the final error code and the success flag, and the
// parser then starts the next stream from its reset state.
module token_stream_parser
    import tsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] byte_echo, [11:8] error_code, [12] stream_ok, zeros
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    t_parse_state r_state;
    logic         r_out_valid;
    t_kind        r_out_kind;
    logic [7:0]   r_out_byte;
    t_error       r_out_error;
    logic         r_out_ok;
    logic         r_out_last;

    t_step_result step;
    logic         out_load;
    logic         in_load;

    tsp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (step)
    );

    assign out_load      = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.phase <= PH_TOP;
            r_state.error <= ERR_NONE;
        end else begin
            if (in_load) r_in_valid <= 1'b1;
            else if (out_load) r_in_valid <= 1'b0;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_state     <= step.next_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (out_load) begin
            r_out_kind  <= step.kind;
            r_out_byte  <= r_in_byte;
            r_out_error <= step.error_code;
            r_out_ok    <= step.stream_ok;
            r_out_last  <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_ok, r_out_error, r_out_byte};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== sv/tsp_step.sv =====
// Per-byte parse step: next phase, sticky error, byte kind and end-of-stream verdict.
module tsp_step
    import tsp_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_step_result o_result
);

    t_phase phase_nxt;
    t_error err_byte;
    t_error err_nxt;
    t_error err_end;
    t_kind  kind;

    always_comb begin
        phase_nxt = i_state.phase;
        err_byte  = ERR_NONE;
        kind      = KIND_SKIP;
        case (i_state.phase)
            PH_NAME: begin
                if (is_letter(i_byte)) begin
                    kind = KIND_NAME;
                end else if (i_byte != CH_SPACE) begin
                    err_byte = ERR_OPEN_DELIM;
                end else begin
                    phase_nxt = PH_OPEN1;
                end
            end
            PH_OPEN1: begin
                if (i_byte != CH_LBRACE) err_byte = ERR_OPEN_DELIM;
                else phase_nxt = PH_OPEN2;
            end
            PH_OPEN2: begin
                if (i_byte != CH_SPACE) err_byte = ERR_OPEN_DELIM;
                else phase_nxt = PH_FIELD;
            end
            PH_FIELD: begin
                if (i_byte == CH_SPACE) begin
                    phase_nxt = PH_FIELD;
                end else if (i_byte == CH_RBRACE) begin
                    kind      = KIND_CLOSE;
                    phase_nxt = PH_TOP;
                end else if (is_ctrl_ws(i_byte)) begin
                    err_byte = ERR_WS_AT_KEY;
                end else if (!is_letter(i_byte)) begin
                    err_byte = ERR_BAD_KEY;
                end else begin
                    kind      = KIND_KEY;
                    phase_nxt = PH_KEY;
                end
            end
            PH_KEY: begin
                if (is_letter(i_byte)) begin
                    kind = KIND_KEY;
                end else if (i_byte != CH_COLON) begin
                    err_byte = ERR_FIELD_DELIM;
                end else begin
                    phase_nxt = PH_DELIM1;
                end
            end
            PH_DELIM1: begin
                if (i_byte != CH_SPACE) err_byte = ERR_FIELD_DELIM;
                else phase_nxt = PH_DELIM2;
            end
            PH_DELIM2: begin
                if (i_byte != CH_QUOTE) err_byte = ERR_FIELD_DELIM;
                else phase_nxt = PH_VSTART;
            end
            PH_VSTART, PH_VALUE: begin
                if (i_byte == CH_QUOTE) begin
                    kind      = KIND_VEND;
                    phase_nxt = PH_FIELD;
                end else begin
                    kind      = KIND_VALUE;
                    phase_nxt = (i_byte == CH_BSLASH) ? PH_ESC : PH_VALUE;
                end
            end
            PH_ESC: begin
                kind      = KIND_VALUE;
                phase_nxt = PH_VALUE;
            end
            default: begin
                if (i_byte == CH_SPACE) begin
                    phase_nxt = PH_TOP;
                end else if (is_ctrl_ws(i_byte)) begin
                    err_byte = ERR_WS_AT_KEY;
                end else if (!is_letter(i_byte)) begin
                    err_byte = ERR_BAD_KEY;
                end else begin
                    kind      = KIND_NAME;
                    phase_nxt = PH_NAME;
                end
            end
        endcase

        // Once an error is latched, bytes are skipped and the state holds until the byte marked last.
        if (i_state.error != ERR_NONE) begin
            phase_nxt = i_state.phase;
            err_nxt   = i_state.error;
            kind      = KIND_SKIP;
        end else if (err_byte != ERR_NONE) begin
            phase_nxt = i_state.phase;
            err_nxt   = err_byte;
            kind      = KIND_SKIP;
        end else begin
            err_nxt = ERR_NONE;
        end

        case (phase_nxt)
            PH_NAME, PH_OPEN1, PH_OPEN2:   err_end = ERR_OPEN_DELIM;
            PH_FIELD:                      err_end = ERR_OPEN_TOKEN;
            PH_KEY, PH_DELIM1, PH_DELIM2:  err_end = ERR_FIELD_DELIM;
            PH_VSTART:                     err_end = ERR_NO_VALUE;
            PH_VALUE:                      err_end = ERR_OPEN_VALUE;
            PH_ESC:                        err_end = ERR_OPEN_ESCAPE;
            default:                       err_end = ERR_NONE;
        endcase

        o_result.kind       = kind;
        o_result.error_code = err_nxt;
        o_result.stream_ok  = 1'b0;
        o_result.next_state.phase = phase_nxt;
        o_result.next_state.error = err_nxt;
        if (i_last) begin
            if (err_nxt == ERR_NONE) o_result.error_code = err_end;
            o_result.stream_ok  = (err_nxt == ERR_NONE) && (err_end == ERR_NONE);
            o_result.next_state.phase = PH_TOP;
            o_result.next_state.error = ERR_NONE;
        end
    end

endmodule
